// ===== src/csd_pkg.sv =====
// ----------------------------------------------------------------------------
// Current settle detector package
// Shared widths, register map, status codes and structs of the detector.
// ----------------------------------------------------------------------------
package csd_pkg;

	// Window geometry.
	localparam int WINDOW_MAX = 16;
	localparam int WIN_AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int WIN_CW     = $clog2(WINDOW_MAX + 1);

	// Field widths.
	localparam int CUR_W      = 16;
	localparam int WLEN_W     = 5;
	localparam int STATUS_W   = 3;

	// Configuration port.
	localparam int APB_AW     = 5;
	localparam int APB_DW     = 32;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_OFFSET    = 3'd0;
	localparam logic [2:0] REG_MIN       = 3'd1;
	localparam logic [2:0] REG_MAX       = 3'd2;
	localparam logic [2:0] REG_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_WIN_LEN   = 3'd4;
	localparam logic [2:0] REG_MAX_SMP   = 3'd5;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_RUNNING = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SETTLED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OVER    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IDLE    = 3'd4;

	// Consecutive over-maximum samples that end a run.
	localparam logic [1:0] OVER_LIMIT = 2'd2;

	// Configuration registers as seen by the sequencer.
	typedef struct packed {
		logic signed [CUR_W-1:0] offset_current;
		logic signed [CUR_W-1:0] min_expected;
		logic signed [CUR_W-1:0] max_expected;
		logic        [CUR_W-1:0] settle_threshold;
		logic        [WLEN_W-1:0] window_len;
		logic        [CUR_W-1:0] max_samples;
	} cfg_t;

	// Access request from the sequencer to the window memory.
	typedef struct packed {
		logic              we;
		logic [WIN_AW-1:0] waddr;
		logic [CUR_W-1:0]  wdata;
		logic              re;
		logic [WIN_AW-1:0] raddr;
	} ram_req_t;

endpackage

// ===== src/csd_in_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one sample item per transfer.
// ----------------------------------------------------------------------------
interface csd_in_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic signed [csd_pkg::CUR_W-1:0] sample_ma;

	modport source (output valid, kind, sample_ma, input ready);
	modport sink (input valid, kind, sample_ma, output ready);
endinterface

// ===== src/csd_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result item per transfer.
// ----------------------------------------------------------------------------
interface csd_out_if;
	logic                            valid;
	logic                            ready;
	logic [csd_pkg::STATUS_W-1:0]    status;
	logic signed [csd_pkg::CUR_W-1:0] value_ma;
	logic                            done_res;

	modport source (output valid, status, value_ma, done_res, input ready);
	modport sink (input valid, status, value_ma, done_res, output ready);
endinterface

// ===== src/csd_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the detector limits and window settings.
// ----------------------------------------------------------------------------
module csd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csd_pkg::APB_AW-1:0]  paddr,
	input  logic [csd_pkg::APB_DW-1:0]  pwdata,
	output logic [csd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output csd_pkg::cfg_t               cfg
);

	csd_pkg::cfg_t cfg_q;
	logic [2:0]    reg_idx;
	logic          wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_current   <= '0;
			cfg_q.min_expected     <= '0;
			cfg_q.max_expected     <= 16'sh7FFF;
			cfg_q.settle_threshold <= '0;
			cfg_q.window_len       <= 5'd3;
			cfg_q.max_samples      <= 16'd10;
		end else if (wr_en) begin
			case (reg_idx)
				csd_pkg::REG_OFFSET:    cfg_q.offset_current   <= pwdata[15:0];
				csd_pkg::REG_MIN:       cfg_q.min_expected     <= pwdata[15:0];
				csd_pkg::REG_MAX:       cfg_q.max_expected     <= pwdata[15:0];
				csd_pkg::REG_THRESHOLD: cfg_q.settle_threshold <= pwdata[15:0];
				csd_pkg::REG_WIN_LEN:   cfg_q.window_len       <= pwdata[4:0];
				csd_pkg::REG_MAX_SMP:   cfg_q.max_samples      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read data, zero-extended to the bus width.
	always_comb begin
		case (reg_idx)
			csd_pkg::REG_OFFSET:    prdata = {16'd0, cfg_q.offset_current};
			csd_pkg::REG_MIN:       prdata = {16'd0, cfg_q.min_expected};
			csd_pkg::REG_MAX:       prdata = {16'd0, cfg_q.max_expected};
			csd_pkg::REG_THRESHOLD: prdata = {16'd0, cfg_q.settle_threshold};
			csd_pkg::REG_WIN_LEN:   prdata = {27'd0, cfg_q.window_len};
			csd_pkg::REG_MAX_SMP:   prdata = {16'd0, cfg_q.max_samples};
			default:                prdata = '0;
		endcase
	end

endmodule

// ===== src/csd_win_ram.sv =====
// ----------------------------------------------------------------------------
// Window memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module csd_win_ram (
	input  logic                       clk,
	input  csd_pkg::ram_req_t          req,
	output logic [csd_pkg::CUR_W-1:0]  rdata
);

	logic [csd_pkg::CUR_W-1:0] mem [csd_pkg::WINDOW_MAX];

	// Synchronous write.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Synchronous read.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== src/csd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Settle sequencer
// Takes one sample item at a time, updates the window memory, scans it for
// its range and produces the result into an output register.
// ----------------------------------------------------------------------------
module csd_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  csd_pkg::cfg_t              cfg,
	csd_in_if.sink                     samples,
	csd_out_if.source                  results,
	output csd_pkg::ram_req_t          ram_req,
	input  logic [csd_pkg::CUR_W-1:0]  ram_rdata
);

	localparam int AW = csd_pkg::WIN_AW;
	localparam int CW = csd_pkg::WIN_CW;
	localparam int DW = csd_pkg::CUR_W;
	localparam int SW = csd_pkg::STATUS_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_FILL   = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;

	logic [2:0]           state_q;
	logic                 kind_q;
	logic signed [DW-1:0] cur_q;
	logic                 running_q;
	logic [AW-1:0]        write_pos_q;
	logic [CW-1:0]        filled_q;
	logic [1:0]           over_q;
	logic [DW-1:0]        taken_q;
	logic [CW-1:0]        idx_q;
	logic                 pend_q;
	logic                 first_q;
	logic                 scanned_q;
	logic signed [DW-1:0] mn_q;
	logic signed [DW-1:0] mx_q;
	logic [SW-1:0]        st_q;
	logic                 done_q;

	logic                 out_valid_q;
	logic [SW-1:0]        out_status_q;
	logic signed [DW-1:0] out_value_q;
	logic                 out_done_q;

	logic                 in_xfer;
	logic                 out_load;
	logic signed [DW:0]   diff;
	logic signed [DW-1:0] corr;
	logic [CW-1:0]        win;
	logic [AW-1:0]        wp_cur;
	logic [CW-1:0]        wp_inc;
	logic [AW-1:0]        wp_next;
	logic [CW-1:0]        filled_inc;
	logic [1:0]           over_inc;
	logic                 is_over;
	logic                 over_end;
	logic                 issue;
	logic signed [DW-1:0] rd_val;
	logic [DW:0]          span;
	logic                 settle;

	// Offset correction with saturation to 16 bits.
	always_comb begin
		diff = {samples.sample_ma[DW-1], samples.sample_ma}
			- {cfg.offset_current[DW-1], cfg.offset_current};
		if (diff[DW] != diff[DW-1]) begin
			corr = diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			corr = diff[DW-1:0];
		end
	end

	// Effective window length, clamped to one through the memory depth.
	always_comb begin
		if (cfg.window_len == '0) begin
			win = CW'(1);
		end else if (32'(cfg.window_len) > 32'(csd_pkg::WINDOW_MAX)) begin
			win = CW'(csd_pkg::WINDOW_MAX);
		end else begin
			win = CW'(cfg.window_len);
		end
	end

	// Write position and counter updates for a running sample.
	always_comb begin
		wp_cur     = (CW'(write_pos_q) >= win) ? '0 : write_pos_q;
		wp_inc     = CW'(wp_cur) + CW'(1);
		wp_next    = (wp_inc >= win) ? '0 : wp_inc[AW-1:0];
		filled_inc = (32'(filled_q) < 32'(csd_pkg::WINDOW_MAX)) ? filled_q + CW'(1) : filled_q;
		is_over    = cur_q > cfg.max_expected;
		over_inc   = (over_q < 2'd3) ? over_q + 2'd1 : over_q;
		over_end   = is_over && (over_inc >= csd_pkg::OVER_LIMIT);
	end

	// Window scan and settle decision.
	assign issue  = (state_q == S_SCAN) && (idx_q < win);
	assign rd_val = ram_rdata;
	assign span   = {mx_q[DW-1], mx_q} - {mn_q[DW-1], mn_q};
	assign settle = scanned_q && (span < {1'b0, cfg.settle_threshold})
		&& (cur_q >= cfg.min_expected) && (cur_q <= cfg.max_expected);

	// Memory access request.
	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = idx_q[AW-1:0];
		ram_req.wdata = cur_q;
		ram_req.re    = issue;
		ram_req.raddr = idx_q[AW-1:0];
		if (state_q == S_FILL) begin
			ram_req.we = 1'b1;
		end else if (state_q == S_EVAL && kind_q && running_q && !over_end) begin
			ram_req.we    = 1'b1;
			ram_req.waddr = wp_cur;
		end
	end

	// Handshakes.
	assign samples.ready    = (state_q == S_IDLE);
	assign in_xfer          = samples.valid && samples.ready;
	assign out_load         = (state_q == S_FIN) && (!out_valid_q || results.ready);
	assign results.valid    = out_valid_q;
	assign results.status   = out_status_q;
	assign results.value_ma = out_value_q;
	assign results.done_res = out_done_q;

	// Item payload captured at the input transfer.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q <= samples.kind;
			cur_q  <= corr;
		end
	end

	// Sequencer and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			running_q   <= 1'b0;
			write_pos_q <= '0;
			filled_q    <= '0;
			over_q      <= '0;
			taken_q     <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			first_q     <= 1'b0;
			scanned_q   <= 1'b0;
			st_q        <= csd_pkg::ST_IDLE;
			done_q      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					idx_q     <= '0;
					pend_q    <= 1'b0;
					first_q   <= 1'b1;
					scanned_q <= 1'b0;
					if (!kind_q) begin
						// Start: clear the run and refill the whole window.
						write_pos_q <= '0;
						filled_q    <= '0;
						over_q      <= '0;
						taken_q     <= '0;
						running_q   <= (cfg.max_samples != '0);
						st_q        <= (cfg.max_samples == '0) ? csd_pkg::ST_TIMEOUT
							: csd_pkg::ST_RUNNING;
						done_q      <= (cfg.max_samples == '0);
						state_q     <= S_FILL;
					end else if (!running_q) begin
						st_q    <= csd_pkg::ST_IDLE;
						done_q  <= 1'b0;
						state_q <= S_FIN;
					end else begin
						taken_q <= taken_q + DW'(1);
						over_q  <= is_over ? over_inc : 2'd0;
						if (over_end) begin
							running_q <= 1'b0;
							st_q      <= csd_pkg::ST_OVER;
							done_q    <= 1'b1;
							state_q   <= S_FIN;
						end else begin
							write_pos_q <= wp_next;
							filled_q    <= filled_inc;
							state_q     <= (filled_inc >= win) ? S_SCAN : S_DECIDE;
						end
					end
				end
				S_FILL: begin
					idx_q <= idx_q + CW'(1);
					if (32'(idx_q) == csd_pkg::WINDOW_MAX - 1) begin
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
					pend_q <= issue;
					if (pend_q) begin
						first_q <= 1'b0;
					end
					if (!issue && !pend_q) begin
						scanned_q <= 1'b1;
						state_q   <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (settle) begin
						running_q <= 1'b0;
						st_q      <= csd_pkg::ST_SETTLED;
						done_q    <= 1'b1;
					end else if (taken_q >= cfg.max_samples) begin
						running_q <= 1'b0;
						st_q      <= csd_pkg::ST_TIMEOUT;
						done_q    <= 1'b1;
					end else begin
						st_q   <= csd_pkg::ST_RUNNING;
						done_q <= 1'b0;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Running minimum and maximum over the scanned entries.
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && pend_q) begin
			if (first_q || rd_val < mn_q) begin
				mn_q <= rd_val;
			end
			if (first_q || rd_val > mx_q) begin
				mx_q <= rd_val;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= st_q;
			out_value_q  <= cur_q;
			out_done_q   <= done_q;
		end
	end

endmodule

// ===== src/current_settle_detector.sv =====
// ----------------------------------------------------------------------------
// Current settle detector
// Watches offset-corrected current samples until a run settles, trips on
// overcurrent or times out.
// ----------------------------------------------------------------------------
// Usage:
//   samples  (sink)   : one item per transfer; kind 0 starts a run with its
//                       first sample, kind 1 is a further sample.
//   results  (source) : exactly one result per sample item, in order.
//   APB port          : six registers at byte addresses 0 to 20, which the
//                       user writes only while the block is idle (unchecked).
// Sequencing: a start item refills the whole window with its sample, one
// window entry a cycle, before its result is produced. A sample item that
// scans the window reads it through the single memory read port, one entry
// a cycle; other items skip the refill and the scan.
// Throughput: one item at a time; the next sample transfer is taken once the
// previous result has moved into the output register.
// Reset: clears the run state and loads the register defaults; the window
// memory is not cleared, a start item fills it.
// A stalled receiver holds the result in the output register; the block then
// finishes the following item and waits with it until the register frees.
// ----------------------------------------------------------------------------
module current_settle_detector (
	input  logic                        clk,
	input  logic                        arst_n,
	csd_in_if.sink                      samples,
	csd_out_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csd_pkg::APB_AW-1:0]  paddr,
	input  logic [csd_pkg::APB_DW-1:0]  pwdata,
	output logic [csd_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	csd_pkg::cfg_t             cfg;
	csd_pkg::ram_req_t         ram_req;
	logic [csd_pkg::CUR_W-1:0] ram_rdata;

	// Register file.
	csd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Window memory.
	csd_win_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Sequencer.
	csd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.samples   (samples),
		.results   (results),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

endmodule
